>>> sv/ppp_pkg.sv
// ----------------------------------------------------------------------------
// Pinhole point projection package
// Payload types, register indexes, status codes and datapath widths used by
// the projection unit.
// ----------------------------------------------------------------------------
package ppp_pkg;

  localparam int unsigned NUM_REGS  = 6;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;

  // Reset matrix gives u = x/z and v = y/z.
  localparam logic [63:0] COEF_RESET [NUM_REGS] = '{
    64'd4096, 64'd0, 64'd17592186044416, 64'd0, 64'd0, 64'd4096
  };

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_DIV = 2'd1;
  localparam logic [1:0] STATUS_SAT      = 2'd2;

  // Row sums of four 64-bit products need 66 bits; their magnitude fits 65.
  localparam int unsigned PROD_W = 64;
  localparam int unsigned SUM_W  = 66;
  localparam int unsigned MAG_W  = 65;
  localparam int unsigned QUO_W  = 32;
  localparam int unsigned REM_W  = MAG_W + QUO_W + 1;

  localparam logic [QUO_W-1:0] LIMIT_POS = 32'h7FFF_FFFF;
  localparam logic [QUO_W-1:0] LIMIT_NEG = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] image_u;
    logic signed [31:0] image_v;
    logic [1:0]         proj_status;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_index;
    logic [63:0]          wdata;
  } cfg_t;

endpackage

>>> sv/ppp_stream_if.sv
// ----------------------------------------------------------------------------
// Pinhole point projection stream interface
// Valid/ready channel with a typed payload; a transaction completes on a
// rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ppp_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);

endinterface

>>> sv/pinhole_point_projection_unit.sv
// ----------------------------------------------------------------------------
// Pinhole point projection unit
// Pipeline: a point accepted at one clock edge passes 4 product/sum stages,
//   33 divider stages, 1 format stage and 1 output register on its way to
//   result_o; the first stage loads at the accepting edge.
// Throughput: one point per cycle while the skid register is empty; the 32
//   restoring divider steps are register stages; no transactions share them.
// Reset: the matrix returns to u = x/z, v = y/z and the pipeline empties.
// ----------------------------------------------------------------------------
module pinhole_point_projection_unit
  import ppp_pkg::*;
#(
  parameter int unsigned POINT_FRAC = 16,
  parameter int unsigned OUT_FRAC   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ppp_stream_if.sink   point_i,
  ppp_stream_if.source result_o,
  ppp_stream_if.sink   cfg_i
);

  typedef struct packed {
    logic [REM_W-1:0] rem_u;
    logic [REM_W-1:0] rem_v;
    logic [MAG_W-1:0] den;
    logic [QUO_W-1:0] quo_u;
    logic [QUO_W-1:0] quo_v;
    logic             neg_u;
    logic             neg_v;
    logic             ovf_u;
    logic             ovf_v;
    logic             zero;
  } div_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0] coef_q [NUM_REGS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        coef_q[i] <= COEF_RESET[i];
      end
    end else if (cfg_i.valid && (cfg_i.payload.reg_index < CFG_IDX_W'(NUM_REGS))) begin
      coef_q[cfg_i.payload.reg_index] <= cfg_i.payload.wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: one enable for all stages, held off while the skid
  // register is occupied.
  // --------------------------------------------------------------------------
  logic    en;
  logic    pop;
  logic    ov_q, sv_q;
  result_t out_q, skid_q;
  logic    fin_v_q;
  result_t fin_q;

  assign en             = !sv_q;
  assign pop            = ov_q && result_o.ready;
  assign point_i.ready  = en;
  assign result_o.valid = ov_q;
  assign result_o.payload = out_q;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic dv_v_q [QUO_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      fin_v_q <= 1'b0;
      for (int i = 0; i <= QUO_W; i++) begin
        dv_v_q[i] <= 1'b0;
      end
    end else if (en) begin
      s1_v_q    <= point_i.valid;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s4_v_q    <= s3_v_q;
      dv_v_q[0] <= s4_v_q;
      for (int i = 0; i < QUO_W; i++) begin
        dv_v_q[i+1] <= dv_v_q[i];
      end
      fin_v_q <= dv_v_q[QUO_W];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: nine 32x32 products; the constant column is a shift.
  // --------------------------------------------------------------------------
  logic signed [PROD_W-1:0] s1_prod_q [3][4];

  function automatic logic signed [PROD_W-1:0] const_term(input logic [31:0] c);
    logic signed [PROD_W-1:0] ext;
    ext = PROD_W'(signed'(c));
    return ext <<< POINT_FRAC;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_prod_q[0][0] <= signed'(coef_q[REG_ROW0_C01][31:0])  * point_i.payload.point_x;
      s1_prod_q[0][1] <= signed'(coef_q[REG_ROW0_C01][63:32]) * point_i.payload.point_y;
      s1_prod_q[0][2] <= signed'(coef_q[REG_ROW0_C23][31:0])  * point_i.payload.point_z;
      s1_prod_q[0][3] <= const_term(coef_q[REG_ROW0_C23][63:32]);
      s1_prod_q[1][0] <= signed'(coef_q[REG_ROW1_C01][31:0])  * point_i.payload.point_x;
      s1_prod_q[1][1] <= signed'(coef_q[REG_ROW1_C01][63:32]) * point_i.payload.point_y;
      s1_prod_q[1][2] <= signed'(coef_q[REG_ROW1_C23][31:0])  * point_i.payload.point_z;
      s1_prod_q[1][3] <= const_term(coef_q[REG_ROW1_C23][63:32]);
      s1_prod_q[2][0] <= signed'(coef_q[REG_ROW2_C01][31:0])  * point_i.payload.point_x;
      s1_prod_q[2][1] <= signed'(coef_q[REG_ROW2_C01][63:32]) * point_i.payload.point_y;
      s1_prod_q[2][2] <= signed'(coef_q[REG_ROW2_C23][31:0])  * point_i.payload.point_z;
      s1_prod_q[2][3] <= const_term(coef_q[REG_ROW2_C23][63:32]);
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2 and 3: exact row sums as a registered adder tree.
  // --------------------------------------------------------------------------
  logic signed [SUM_W-2:0] s2_pair_q [3][2];
  logic signed [SUM_W-1:0] s3_sum_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s2_pair_q[r][0] <= (SUM_W-1)'(s1_prod_q[r][0]) + (SUM_W-1)'(s1_prod_q[r][1]);
        s2_pair_q[r][1] <= (SUM_W-1)'(s1_prod_q[r][2]) + (SUM_W-1)'(s1_prod_q[r][3]);
        s3_sum_q[r]     <= SUM_W'(s2_pair_q[r][0]) + SUM_W'(s2_pair_q[r][1]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: magnitudes, quotient signs and the zero-divisor flag.
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0] s4_mag_q [3];
  logic             s4_neg_u_q, s4_neg_v_q, s4_zero_q;
  logic [SUM_W-1:0] s3_abs [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s3_abs[r] = s3_sum_q[r][SUM_W-1] ? SUM_W'(-s3_sum_q[r]) : SUM_W'(s3_sum_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        s4_mag_q[r] <= s3_abs[r][MAG_W-1:0];
      end
      s4_neg_u_q <= s3_sum_q[0][SUM_W-1] ^ s3_sum_q[2][SUM_W-1];
      s4_neg_v_q <= s3_sum_q[1][SUM_W-1] ^ s3_sum_q[2][SUM_W-1];
      s4_zero_q  <= (s3_sum_q[2] == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: scale the numerators and flag quotients of 2^32 or more, which
  // saturate regardless of the low bits.
  // --------------------------------------------------------------------------
  div_t             dv_q [QUO_W+1];
  logic [REM_W-1:0] s4_num_u, s4_num_v, s4_den_top;

  assign s4_num_u   = REM_W'(s4_mag_q[0]) << OUT_FRAC;
  assign s4_num_v   = REM_W'(s4_mag_q[1]) << OUT_FRAC;
  assign s4_den_top = REM_W'(s4_mag_q[2]) << QUO_W;

  // --------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage, most significant first,
  // for both coordinates against the shared divisor.
  // --------------------------------------------------------------------------
  function automatic div_t div_step(input div_t cur, input int unsigned shift);
    div_t             nxt;
    logic [REM_W-1:0] den_sh;
    logic             take_u, take_v;
    nxt    = cur;
    den_sh = REM_W'(cur.den) << shift;
    take_u = (cur.rem_u >= den_sh);
    take_v = (cur.rem_v >= den_sh);
    if (take_u) nxt.rem_u = cur.rem_u - den_sh;
    if (take_v) nxt.rem_v = cur.rem_v - den_sh;
    nxt.quo_u = {cur.quo_u[QUO_W-2:0], take_u};
    nxt.quo_v = {cur.quo_v[QUO_W-2:0], take_v};
    return nxt;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0].rem_u <= s4_num_u;
      dv_q[0].rem_v <= s4_num_v;
      dv_q[0].den   <= s4_mag_q[2];
      dv_q[0].quo_u <= '0;
      dv_q[0].quo_v <= '0;
      dv_q[0].neg_u <= s4_neg_u_q;
      dv_q[0].neg_v <= s4_neg_v_q;
      dv_q[0].ovf_u <= (s4_num_u >= s4_den_top);
      dv_q[0].ovf_v <= (s4_num_v >= s4_den_top);
      dv_q[0].zero  <= s4_zero_q;
      for (int k = 0; k < QUO_W; k++) begin
        dv_q[k+1] <= div_step(dv_q[k], QUO_W - 1 - k);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Format stage: saturate, apply the sign, choose the status.
  // --------------------------------------------------------------------------
  logic [QUO_W-1:0] lim_u, lim_v, mag_u, mag_v;
  logic             sat_u, sat_v;
  result_t          fin_d;

  always_comb begin
    lim_u = dv_q[QUO_W].neg_u ? LIMIT_NEG : LIMIT_POS;
    lim_v = dv_q[QUO_W].neg_v ? LIMIT_NEG : LIMIT_POS;
    sat_u = dv_q[QUO_W].ovf_u || (dv_q[QUO_W].quo_u > lim_u);
    sat_v = dv_q[QUO_W].ovf_v || (dv_q[QUO_W].quo_v > lim_v);
    mag_u = sat_u ? lim_u : dv_q[QUO_W].quo_u;
    mag_v = sat_v ? lim_v : dv_q[QUO_W].quo_v;
    if (dv_q[QUO_W].zero) begin
      fin_d.image_u     = '0;
      fin_d.image_v     = '0;
      fin_d.proj_status = STATUS_ZERO_DIV;
    end else begin
      fin_d.image_u     = dv_q[QUO_W].neg_u ? signed'(-mag_u) : signed'(mag_u);
      fin_d.image_v     = dv_q[QUO_W].neg_v ? signed'(-mag_v) : signed'(mag_v);
      fin_d.proj_status = (sat_u || sat_v) ? STATUS_SAT : STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= fin_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with skid stage. A result leaving the pipeline goes to
  // the output register if it is free or being emptied, else to the skid.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (pop) begin
        sv_q <= 1'b0;
      end
    end else if (fin_v_q) begin
      if (!ov_q || pop) begin
        ov_q <= 1'b1;
      end else begin
        sv_q <= 1'b1;
      end
    end else if (pop) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (fin_v_q) begin
      if (!ov_q || pop) begin
        out_q <= fin_q;
      end else begin
        skid_q <= fin_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid register holds a result while the output register is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sv_q) |-> $past(ov_q && !result_o.ready && fin_v_q))
    else $error("skid register filled without a stalled output");

  a_zero_div_outputs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.payload.proj_status == STATUS_ZERO_DIV))
      |-> (result_o.payload.image_u == '0) && (result_o.payload.image_v == '0))
    else $error("zero-divisor result carries nonzero coordinates");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.payload.proj_status == STATUS_OK) ||
                       (result_o.payload.proj_status == STATUS_ZERO_DIV) ||
                       (result_o.payload.proj_status == STATUS_SAT))
    else $error("undefined projection status");

endmodule
